>>> sv/wmo_pkg.sv
// shared types, constants and sequencer encodings of the morphing wavetable oscillator
package wmo_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int VALUE_W     = 16;
    localparam int INDEX_W     = 8;
    localparam int PHASE_W     = 32;
    localparam int WEIGHT_W    = 9;
    localparam int FULL_WEIGHT = 256;
    localparam int MIX_SHIFT   = $clog2(FULL_WEIGHT);
    localparam int OUT_SCALE   = 20000;
    localparam int SCALE_W     = 15;
    localparam int HALF_SPAN   = 32768;
    localparam int SPAN_SHIFT  = 15;
    localparam int OUT_SHIFT   = MIX_SHIFT + SPAN_SHIFT - SCALE_W;
    localparam int QUO_W       = VALUE_W + 1;
    localparam int NORM_W      = QUO_W;
    localparam int ACC_W       = 26;
    localparam int MULT_W      = (SCALE_W > WEIGHT_W) ? SCALE_W : WEIGHT_W;
    localparam int SAMPLE_W    = 16;
    localparam int CFG_W       = 32;
    localparam int CNT_W       = $clog2(QUO_W + 1);

    typedef logic [ADDR_W-1:0]          addr_t;
    typedef logic [VALUE_W-1:0]         value_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [PHASE_W-1:0]         phase_t;
    typedef logic [WEIGHT_W-1:0]        weight_t;
    typedef logic [QUO_W-1:0]           quo_t;
    typedef logic signed [NORM_W-1:0]   norm_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [MULT_W-1:0]          mult_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [CFG_W-1:0]           cfg_data_t;
    typedef logic [0:0]                 cfg_idx_t;
    typedef logic [CNT_W-1:0]           cnt_t;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_TICK     = 1'b1;
    localparam logic SEL_FIRST    = 1'b0;
    localparam logic SEL_SECOND   = 1'b1;

    localparam cfg_idx_t REG_PHASE_STEP   = cfg_idx_t'(0);
    localparam cfg_idx_t REG_MORPH_WEIGHT = cfg_idx_t'(1);

    localparam phase_t  PHASE_STEP_RESET = phase_t'(13421773);
    localparam weight_t FULL_W           = weight_t'(FULL_WEIGHT);
    localparam quo_t    HALF_Q           = quo_t'(HALF_SPAN);
    localparam mult_t   SCALE_BITS       = mult_t'(OUT_SCALE);
    localparam value_t  VALUE_ALL_ONES   = '1;

    localparam cnt_t DIV_LAST   = cnt_t'(QUO_W - 1);
    localparam cnt_t MIX_LAST   = cnt_t'(WEIGHT_W - 1);
    localparam cnt_t SCALE_LAST = cnt_t'(SCALE_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_PREP,
        ST_MIX,
        ST_TURN,
        ST_SCALE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic div_start;
        logic div_step;
        logic mix_start;
        logic mix_step;
        logic scale_start;
        logic scale_step;
    } seq_ctl_t;

endpackage

>>> sv/wmo_table.sv
// one wavetable memory with its running minimum and maximum
module wmo_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  wmo_pkg::addr_t  wr_addr,
    input  wmo_pkg::value_t wr_data,
    input  logic            rd_en,
    input  wmo_pkg::addr_t  rd_addr,
    output wmo_pkg::value_t rd_data,
    output wmo_pkg::value_t minimum,
    output wmo_pkg::value_t maximum
);

    wmo_pkg::value_t mem [wmo_pkg::TABLE_DEPTH];
    wmo_pkg::value_t rd_data_reg;
    wmo_pkg::value_t min_reg;
    wmo_pkg::value_t max_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= wmo_pkg::VALUE_ALL_ONES;
            max_reg <= '0;
        end
        else if (wr_en)
        begin
            if (wr_data < min_reg)
            begin
                min_reg <= wr_data;
            end
            if (wr_data > max_reg)
            begin
                max_reg <= wr_data;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign minimum = min_reg;
    assign maximum = max_reg;

endmodule

>>> sv/wmo_div.sv
// bit-serial restoring divider for the normalization quotient
module wmo_div (
    input  logic              clk,
    input  logic              rst_n,
    input  wmo_pkg::seq_ctl_t ctl,
    input  wmo_pkg::value_t   value,
    input  wmo_pkg::value_t   minimum,
    input  wmo_pkg::value_t   maximum,
    output wmo_pkg::quo_t     quotient
);

    wmo_pkg::quo_t   rem_reg;
    wmo_pkg::quo_t   quo_reg;
    wmo_pkg::value_t den_reg;
    logic            first_reg;
    wmo_pkg::quo_t   trial;
    wmo_pkg::quo_t   diff;
    logic            ge;

    always_comb
    begin
        trial = first_reg ? rem_reg : {rem_reg[wmo_pkg::QUO_W-2:0], 1'b0};
        ge    = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            rem_reg <= {1'b0, value - minimum};
            den_reg <= maximum - minimum;
            quo_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            rem_reg <= ge ? diff : trial;
            quo_reg <= {quo_reg[wmo_pkg::QUO_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b0;
        end
        else if (ctl.div_start)
        begin
            first_reg <= 1'b1;
        end
        else if (ctl.div_step)
        begin
            first_reg <= 1'b0;
        end
    end

    assign quotient = quo_reg;

endmodule

>>> sv/wmo_mix.sv
// bit-serial crossfade and output scaling with truncation toward zero
module wmo_mix (
    input  logic              clk,
    input  logic              rst_n,
    input  wmo_pkg::seq_ctl_t ctl,
    input  wmo_pkg::quo_t     quo_a,
    input  wmo_pkg::quo_t     quo_b,
    input  wmo_pkg::weight_t  weight,
    output wmo_pkg::sample_t  sample
);

    wmo_pkg::acc_t  acc_reg;
    wmo_pkg::acc_t  mcand_reg;
    wmo_pkg::mult_t mult_reg;
    logic           sticky_reg;
    wmo_pkg::norm_t n1;
    wmo_pkg::norm_t n2;
    wmo_pkg::acc_t  addend;
    wmo_pkg::acc_t  sum;
    wmo_pkg::acc_t  floor_q;
    wmo_pkg::acc_t  res;
    logic           lost;
    logic           rnd;

    always_comb
    begin
        n1      = wmo_pkg::norm_t'(quo_a - wmo_pkg::HALF_Q);
        n2      = wmo_pkg::norm_t'(quo_b - wmo_pkg::HALF_Q);
        addend  = mult_reg[0] ? mcand_reg : '0;
        sum     = acc_reg + addend;
        floor_q = acc_reg >>> wmo_pkg::OUT_SHIFT;
        lost    = sticky_reg | (|acc_reg[wmo_pkg::OUT_SHIFT-1:0]);
        rnd     = acc_reg[wmo_pkg::ACC_W-1] & lost;
        res     = floor_q + wmo_pkg::acc_t'(rnd);
        sample  = res[wmo_pkg::SAMPLE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mix_start)
        begin
            acc_reg   <= wmo_pkg::acc_t'(n1) <<< wmo_pkg::MIX_SHIFT;
            mcand_reg <= wmo_pkg::acc_t'(n2) - wmo_pkg::acc_t'(n1);
            mult_reg  <= wmo_pkg::mult_t'(weight);
        end
        else if (ctl.mix_step)
        begin
            acc_reg   <= sum;
            mcand_reg <= mcand_reg <<< 1;
            mult_reg  <= mult_reg >> 1;
        end
        else if (ctl.scale_start)
        begin
            acc_reg   <= '0;
            mcand_reg <= acc_reg;
            mult_reg  <= wmo_pkg::SCALE_BITS;
        end
        else if (ctl.scale_step)
        begin
            acc_reg  <= sum >>> 1;
            mult_reg <= mult_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sticky_reg <= 1'b0;
        end
        else if (ctl.scale_start)
        begin
            sticky_reg <= 1'b0;
        end
        else if (ctl.scale_step)
        begin
            sticky_reg <= sticky_reg | sum[0];
        end
    end

endmodule

>>> sv/morphing_wavetable_oscillator_top.sv
// morphing wavetable oscillator: two tables, phase accumulator, serial normalize and crossfade
// load item: no result; a load may follow every cycle while the sequencer is idle
// tick item: READ, DIV, PREP, MIX, TURN, SCALE, DONE in order; DONE waits for a free output register
// the 17-step serial divider, 9-step weight multiply and 15-step scale multiply run in DIV, MIX, SCALE
// tick with a flat table: READ goes straight to DONE and the sample is 0; items are taken only in IDLE
// reset: phase 0, min/max to empty, phase_step 13421773, morph_weight 0; table contents undefined
module morphing_wavetable_oscillator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                cmd,
    input  logic                table_select,
    input  wmo_pkg::index_t     entry_index,
    input  wmo_pkg::value_t     entry_value,
    output logic                out_valid,
    input  logic                out_ready,
    output wmo_pkg::sample_t    sample,
    output logic                flat_table,
    input  logic                cfg_write,
    input  wmo_pkg::cfg_idx_t   cfg_index,
    input  wmo_pkg::cfg_data_t  cfg_data
);

    wmo_pkg::state_t    state_reg;
    wmo_pkg::state_t    state_next;
    wmo_pkg::cnt_t      cnt_reg;
    wmo_pkg::phase_t    phase_reg;
    wmo_pkg::phase_t    phase_step_reg;
    wmo_pkg::weight_t   morph_weight_reg;
    logic               flat_reg;
    logic               out_valid_reg;
    wmo_pkg::sample_t   sample_reg;
    logic               flat_out_reg;
    wmo_pkg::seq_ctl_t  ctl;
    logic               out_free;
    logic               done_fire;
    logic               accept;
    logic               tick_fire;
    logic               load_fire;
    logic               in_range;
    logic               wr_a;
    logic               wr_b;
    wmo_pkg::addr_t     wr_addr;
    wmo_pkg::addr_t     rd_addr;
    wmo_pkg::value_t    rd_a;
    wmo_pkg::value_t    rd_b;
    wmo_pkg::value_t    min_a;
    wmo_pkg::value_t    max_a;
    wmo_pkg::value_t    min_b;
    wmo_pkg::value_t    max_b;
    wmo_pkg::quo_t      quo_a;
    wmo_pkg::quo_t      quo_b;
    wmo_pkg::weight_t   weight_sat;
    wmo_pkg::sample_t   mix_sample;

    always_comb
    begin
        accept     = in_valid & in_ready;
        tick_fire  = accept & (cmd == wmo_pkg::CMD_TICK);
        in_range   = 32'(entry_index) < 32'(wmo_pkg::TABLE_DEPTH);
        load_fire  = accept & (cmd == wmo_pkg::CMD_LOAD) & in_range;
        wr_a       = load_fire & (table_select == wmo_pkg::SEL_FIRST);
        wr_b       = load_fire & (table_select == wmo_pkg::SEL_SECOND);
        wr_addr    = wmo_pkg::addr_t'(entry_index);
        rd_addr    = phase_reg[wmo_pkg::PHASE_W-1 -: wmo_pkg::ADDR_W];
        weight_sat = (morph_weight_reg > wmo_pkg::FULL_W) ? wmo_pkg::FULL_W : morph_weight_reg;
        out_free   = ~out_valid_reg | out_ready;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wmo_pkg::ST_IDLE:
            begin
                if (in_valid && cmd == wmo_pkg::CMD_TICK)
                begin
                    state_next = wmo_pkg::ST_READ;
                end
            end
            wmo_pkg::ST_READ:
            begin
                state_next = flat_reg ? wmo_pkg::ST_DONE : wmo_pkg::ST_DIV;
            end
            wmo_pkg::ST_DIV:
            begin
                if (cnt_reg == wmo_pkg::DIV_LAST)
                begin
                    state_next = wmo_pkg::ST_PREP;
                end
            end
            wmo_pkg::ST_PREP:
            begin
                state_next = wmo_pkg::ST_MIX;
            end
            wmo_pkg::ST_MIX:
            begin
                if (cnt_reg == wmo_pkg::MIX_LAST)
                begin
                    state_next = wmo_pkg::ST_TURN;
                end
            end
            wmo_pkg::ST_TURN:
            begin
                state_next = wmo_pkg::ST_SCALE;
            end
            wmo_pkg::ST_SCALE:
            begin
                if (cnt_reg == wmo_pkg::SCALE_LAST)
                begin
                    state_next = wmo_pkg::ST_DONE;
                end
            end
            wmo_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = wmo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wmo_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready        = 1'b0;
        done_fire       = 1'b0;
        ctl             = '0;
        unique case (state_reg)
            wmo_pkg::ST_IDLE:  in_ready        = 1'b1;
            wmo_pkg::ST_READ:  ctl.div_start   = 1'b1;
            wmo_pkg::ST_DIV:   ctl.div_step    = 1'b1;
            wmo_pkg::ST_PREP:  ctl.mix_start   = 1'b1;
            wmo_pkg::ST_MIX:   ctl.mix_step    = 1'b1;
            wmo_pkg::ST_TURN:  ctl.scale_start = 1'b1;
            wmo_pkg::ST_SCALE: ctl.scale_step  = 1'b1;
            wmo_pkg::ST_DONE:  done_fire       = out_free;
            default:           in_ready        = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wmo_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg   <= wmo_pkg::PHASE_STEP_RESET;
            morph_weight_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wmo_pkg::REG_PHASE_STEP:   phase_step_reg   <= cfg_data;
                wmo_pkg::REG_MORPH_WEIGHT: morph_weight_reg <= cfg_data[wmo_pkg::WEIGHT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            flat_reg  <= 1'b0;
        end
        else if (tick_fire)
        begin
            phase_reg <= phase_reg + phase_step_reg;
            flat_reg  <= (max_a <= min_a) | (max_b <= min_b);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_fire)
        begin
            sample_reg   <= flat_reg ? '0 : mix_sample;
            flat_out_reg <= flat_reg;
        end
    end

    wmo_table u_table_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_en   (tick_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_a),
        .minimum (min_a),
        .maximum (max_a)
    );

    wmo_table u_table_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (entry_value),
        .rd_en   (tick_fire),
        .rd_addr (rd_addr),
        .rd_data (rd_b),
        .minimum (min_b),
        .maximum (max_b)
    );

    wmo_div u_div_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .value    (rd_a),
        .minimum  (min_a),
        .maximum  (max_a),
        .quotient (quo_a)
    );

    wmo_div u_div_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .value    (rd_b),
        .minimum  (min_b),
        .maximum  (max_b),
        .quotient (quo_b)
    );

    wmo_mix u_mix (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .quo_a  (quo_a),
        .quo_b  (quo_b),
        .weight (weight_sat),
        .sample (mix_sample)
    );

    assign out_valid  = out_valid_reg;
    assign sample     = sample_reg;
    assign flat_table = flat_out_reg;

endmodule

>>> bench/morphing_wavetable_oscillator_top_test.sv
// self-checking testbench of the morphing wavetable oscillator: directed plan, then random phases
`timescale 1ns / 1ps

module morphing_wavetable_oscillator_top_test;
    import wmo_pkg::*;

    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 135;
    localparam int WINDOW_CENTER  = 35000;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_FILL,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      cmd;
        logic      sel;
        index_t    idx;
        value_t    val;
        phase_t    step;
        weight_t   weight;
        logic      typed;
        sample_t   exp_sample;
        logic      exp_flat;
    } plan_row_t;

    typedef struct packed {
        sample_t sample;
        logic    flat;
    } osc_result_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    logic      cmd;
    logic      table_select;
    index_t    entry_index;
    value_t    entry_value;
    logic      out_valid;
    logic      out_ready;
    sample_t   sample;
    logic      flat_table;
    logic      cfg_write;
    cfg_idx_t  cfg_index;
    cfg_data_t cfg_data;

    value_t      tab_a [TABLE_DEPTH];
    value_t      tab_b [TABLE_DEPTH];
    value_t      lo_a;
    value_t      hi_a;
    value_t      lo_b;
    value_t      hi_b;
    phase_t      phase_acc;
    phase_t      step_reg;
    weight_t     weight_reg;

    osc_result_t sample_queue [$];
    plan_row_t   plan [$];
    osc_result_t want;
    int          mismatches;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    morphing_wavetable_oscillator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .table_select (table_select),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (sample),
        .flat_table   (flat_table),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint norm_entry(value_t v, value_t lo, value_t hi);
        longint num;
        num = (longint'(v) - longint'(lo)) * 2 * HALF_SPAN;
        return num / (longint'(hi) - longint'(lo)) - HALF_SPAN;
    endfunction

    function automatic osc_result_t next_sample();
        osc_result_t r;
        addr_t       k;
        longint      w;
        longint      mix;
        longint      res;
        k   = phase_acc[PHASE_W-1 -: ADDR_W];
        res = 0;
        r.flat = (hi_a <= lo_a) || (hi_b <= lo_b);
        if (!r.flat)
        begin
            w   = (weight_reg > FULL_WEIGHT) ? FULL_WEIGHT : longint'(weight_reg);
            mix = norm_entry(tab_a[k], lo_a, hi_a) * (FULL_WEIGHT - w)
                + norm_entry(tab_b[k], lo_b, hi_b) * w;
            res = (mix * OUT_SCALE) / (longint'(FULL_WEIGHT) * HALF_SPAN);
        end
        r.sample  = sample_t'(res[SAMPLE_W-1:0]);
        phase_acc = phase_acc + step_reg;
        return r;
    endfunction

    task automatic store_entry(logic s, index_t i, value_t v);
        if (s == SEL_FIRST)
        begin
            tab_a[i] = v;
            if (v < lo_a) lo_a = v;
            if (v > hi_a) hi_a = v;
        end
        else
        begin
            tab_b[i] = v;
            if (v < lo_b) lo_b = v;
            if (v > hi_b) hi_b = v;
        end
    endtask

    task automatic issue(logic c, logic s, index_t i, value_t v,
                         logic typed, sample_t es, logic ef);
        osc_result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        table_select <= s;
        entry_index  <= i;
        entry_value  <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (c == CMD_TICK)
        begin
            r = next_sample();
            if (typed)
            begin
                r.sample = es;
                r.flat   = ef;
            end
            sample_queue.push_back(r);
        end
        else
            store_entry(s, i, v);
    endtask

    task automatic set_regs(phase_t st, weight_t wt);
        in_valid <= 1'b0;
        while (sample_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_PHASE_STEP;
        cfg_data  <= cfg_data_t'(st);
        @(posedge clk);
        cfg_index <= REG_MORPH_WEIGHT;
        cfg_data  <= cfg_data_t'(wt);
        @(posedge clk);
        cfg_write  <= 1'b0;
        step_reg   = st;
        weight_reg = wt;
    endtask

    task automatic plan_row(row_kind_t kd, logic c, logic s, index_t i, value_t v,
                            phase_t st, weight_t wt, logic typed, sample_t es, logic ef);
        plan_row_t row;
        row.kind       = kd;
        row.cmd        = c;
        row.sel        = s;
        row.idx        = i;
        row.val        = v;
        row.step       = st;
        row.weight     = wt;
        row.typed      = typed;
        row.exp_sample = es;
        row.exp_flat   = ef;
        plan.push_back(row);
    endtask

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (sample_queue.size() == 0)
            begin
                $display("%0t: result with nothing pending: expected none, got sample %0d flat %0b",
                         $time, sample, flat_table);
                mismatches++;
            end
            else
            begin
                want = sample_queue.pop_front();
                if (sample !== want.sample)
                begin
                    $display("%0t: sample mismatch: expected %0d, got %0d",
                             $time, want.sample, sample);
                    mismatches++;
                end
                if (flat_table !== want.flat)
                begin
                    $display("%0t: flat_table mismatch: expected %0b, got %0b",
                             $time, want.flat, flat_table);
                    mismatches++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("morphing_wavetable_oscillator_top_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic   c;
        logic   s;
        index_t i;
        value_t v;
        int     half;
        phase_t st;
        weight_t wt;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        cmd          <= CMD_LOAD;
        table_select <= SEL_FIRST;
        entry_index  <= '0;
        entry_value  <= '0;
        out_ready    <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= REG_PHASE_STEP;
        cfg_data     <= '0;
        mismatches     = 0;
        idle_cycles    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        lo_a       = VALUE_ALL_ONES;
        hi_a       = '0;
        lo_b       = VALUE_ALL_ONES;
        hi_b       = '0;
        phase_acc  = '0;
        step_reg   = PHASE_STEP_RESET;
        weight_reg = '0;

        // empty tables, then at least one single-valued table: all flat
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd255, 16'hFFFF, 0, 0, 1, 0, 1);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_FIRST, 8'd0, 16'd31000, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 1, 0, 1);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_SECOND, 8'd0, 16'd39500, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd85, 16'h5555, 0, 0, 1, 0, 1);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_FIRST, 8'd1, 16'd31001, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd170, 16'hAAAA, 0, 0, 1, 0, 1);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_SECOND, 8'd255, 16'd39500, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd0, 16'hFFFF, 0, 0, 1, 0, 1);
        plan_row(ROW_FILL, CMD_LOAD, SEL_FIRST, 8'd0, 16'd0, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd170, 16'hAAAA, 0, 0, 0, 0, 0);
        plan_row(ROW_CFG, CMD_LOAD, SEL_FIRST, 8'd0, 16'd0, 32'h8000_0000, 9'd256, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd255, 16'hFFFF, 0, 0, 0, 0, 0);
        plan_row(ROW_CFG, CMD_LOAD, SEL_FIRST, 8'd0, 16'd0, 32'hFFFF_FFFF, 9'd511, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd85, 16'h5555, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_SECOND, 8'd3, 16'd39700, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd0, 16'h0000, 0, 0, 0, 0, 0);
        plan_row(ROW_CFG, CMD_LOAD, SEL_FIRST, 8'd0, 16'd0, 32'h0000_0000, 9'd128, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_LOAD, SEL_FIRST, 8'd7, 16'd31500, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 0, 0, 0);
        plan_row(ROW_CFG, CMD_LOAD, SEL_FIRST, 8'd0, 16'd0, 32'h0100_0000, 9'd1, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_SECOND, 8'd255, 16'hFFFF, 0, 0, 0, 0, 0);
        plan_row(ROW_ITEM, CMD_TICK, SEL_FIRST, 8'd0, 16'h0000, 0, 0, 0, 0, 0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < plan.size(); n++)
        begin
            case (plan[n].kind)
                ROW_ITEM:
                    issue(plan[n].cmd, plan[n].sel, plan[n].idx, plan[n].val,
                          plan[n].typed, plan[n].exp_sample, plan[n].exp_flat);
                ROW_FILL:
                begin
                    // narrow ramps so the ranges widen only gradually later
                    for (int a = 0; a < TABLE_DEPTH; a++)
                        issue(CMD_LOAD, SEL_FIRST, index_t'(a), value_t'(30000 + 7 * a), 0, 0, 0);
                    for (int a = 0; a < TABLE_DEPTH; a++)
                        issue(CMD_LOAD, SEL_SECOND, index_t'(a), value_t'(40000 - 3 * a), 0, 0, 0);
                end
                ROW_CFG:
                    set_regs(plan[n].step, plan[n].weight);
                default:
                    ;
            endcase
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: begin st = PHASE_STEP_RESET; wt = 9'd0;   end
                1: begin st = 32'h8000_0000;    wt = 9'd256; end
                2: begin st = 32'h0000_0000;    wt = 9'd128; end
                3: begin st = 32'hFFFF_FFFF;    wt = 9'd511; end
                4: begin st = $urandom;         wt = weight_t'($urandom_range(511)); end
                5: begin st = 32'h0000_0001;    wt = 9'd1;   end
                6: begin st = $urandom;         wt = weight_t'($urandom_range(511)); end
                default: begin st = $urandom;   wt = 9'd255; end
            endcase
            set_regs(st, wt);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            half = 16 << (2 * p);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                c = ($urandom_range(99) < 45) ? CMD_TICK : CMD_LOAD;
                s = 1'($urandom_range(1));
                i = index_t'($urandom_range(TABLE_DEPTH - 1));
                if (p < 6)
                    v = value_t'(WINDOW_CENTER - half + int'($urandom_range(2 * half)));
                else
                begin
                    case ($urandom_range(7))
                        0:       v = '0;
                        1:       v = VALUE_ALL_ONES;
                        default: v = value_t'($urandom_range(65535));
                    endcase
                end
                issue(c, s, i, v, 0, 0, 0);
            end
        end

        in_valid <= 1'b0;
        while (sample_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("morphing_wavetable_oscillator_top_test: done, clean");
        else
            $display("morphing_wavetable_oscillator_top_test: done, errors");
        $finish;
    end

endmodule
